// File: rtl/core/pva_pkg.sv
`default_nettype none
package pva_pkg;

  localparam int DELTA_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int STAMP_BITS = 32;
  localparam int CFG_BITS   = 32;

  localparam logic [1:0] REG_ACCEL_GAIN  = 2'd0;
  localparam logic [1:0] REG_SENSITIVITY = 2'd1;
  localparam logic [1:0] REG_TICK_RATE   = 2'd2;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_SQX  = 4'd2;
  localparam logic [3:0] OP_SQY  = 4'd3;
  localparam logic [3:0] OP_ROOT = 4'd4;
  localparam logic [3:0] OP_MULA = 4'd5;
  localparam logic [3:0] OP_MULL = 4'd6;
  localparam logic [3:0] OP_MULH = 4'd7;
  localparam logic [3:0] OP_DSET = 4'd8;
  localparam logic [3:0] OP_DIV  = 4'd9;
  localparam logic [3:0] OP_GAIN = 4'd10;
  localparam logic [3:0] OP_AXX  = 4'd11;
  localparam logic [3:0] OP_AXY  = 4'd12;
  localparam logic [3:0] OP_FIN  = 4'd13;

  localparam logic [5:0] ROOT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd40;

  localparam logic [38:0] ACC_MAX   = 39'h7F_FFFE_FFFF;
  localparam logic [33:0] SAT_TH    = 34'h2_0000_0000;
  localparam logic [9:0]  MS_PER_S  = 10'd1000;

  typedef struct packed {
    logic [3:0] op;
  } pva_cmd_t;

  typedef struct packed {
    logic item_abs;
  } pva_status_t;

endpackage
`default_nettype wire

// File: rtl/core/pva_if.sv
`default_nettype none
interface pva_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic        [31:0] stamp;
  logic               absolute;
  modport source (output valid, delta_x, delta_y, stamp, absolute, input ready);
  modport sink (input valid, delta_x, delta_y, stamp, absolute, output ready);
endinterface

interface pva_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  modport source (output valid, out_x, out_y, input ready);
  modport sink (input valid, out_x, out_y, output ready);
endinterface
`default_nettype wire

// File: rtl/core/pva_ctrl.sv
`default_nettype none
module pva_ctrl
  import pva_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire pva_status_t status,
  output pva_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_ROOT = 4'd3;
  localparam logic [3:0] S_MULA = 4'd4;
  localparam logic [3:0] S_MULL = 4'd5;
  localparam logic [3:0] S_MULH = 4'd6;
  localparam logic [3:0] S_DSET = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_GAIN = 4'd9;
  localparam logic [3:0] S_AXX  = 4'd10;
  localparam logic [3:0] S_AXY  = 4'd11;
  localparam logic [3:0] S_FIN  = 4'd12;

  logic [3:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       out_valid_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd.op         = OP_NONE;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.op     = OP_LOAD;
          state_next = status.item_abs ? S_FIN : S_SQX;
        end
      end
      S_SQX: begin
        cmd.op     = OP_SQX;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.op     = OP_SQY;
        cnt_next   = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.op   = OP_ROOT;
        cnt_next = cnt + 6'd1;
        if (cnt == ROOT_STEPS - 6'd1) begin
          state_next = S_MULA;
        end
      end
      S_MULA: begin
        cmd.op     = OP_MULA;
        state_next = S_MULL;
      end
      S_MULL: begin
        cmd.op     = OP_MULL;
        state_next = S_MULH;
      end
      S_MULH: begin
        cmd.op     = OP_MULH;
        state_next = S_DSET;
      end
      S_DSET: begin
        cmd.op     = OP_DSET;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIV;
        cnt_next = cnt + 6'd1;
        if (cnt == DIV_STEPS - 6'd1) begin
          state_next = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.op     = OP_GAIN;
        state_next = S_AXX;
      end
      S_AXX: begin
        cmd.op     = OP_AXX;
        state_next = S_AXY;
      end
      S_AXY: begin
        cmd.op     = OP_AXY;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.op         = OP_FIN;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("controller stayed idle after taking a word");

  a_drop_only_when_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result word withdrawn before it was taken");

  a_fin_commits: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !out_valid) |=> (out_valid && state == S_IDLE))
    else $error("finished result not placed in the output register");

endmodule
`default_nettype wire

// File: rtl/core/pva_datapath.sv
`default_nettype none
module pva_datapath
  import pva_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_BITS-1:0]   cfg_data,
  input  wire logic signed [15:0]    in_delta_x,
  input  wire logic signed [15:0]    in_delta_y,
  input  wire logic [STAMP_BITS-1:0] in_stamp,
  input  wire logic                  in_absolute,
  input  wire pva_cmd_t              cmd,
  output pva_status_t                status,
  output logic signed [15:0]         out_x,
  output logic signed [15:0]         out_y
);

  logic [23:0] accel_gain, sensitivity;
  logic [31:0] tick_rate;
  logic [31:0] last_stamp;
  logic [15:0] rem_x, rem_y;

  logic signed [15:0] dx, dy;
  logic               abs_flag;
  logic [15:0]        ax, ay;
  logic [31:0]        sq;
  logic [31:0]        elapsed;
  logic [41:0]        dvs;
  logic [63:0]        root_n, root_res, root_bit;
  logic [55:0]        pa;
  logic [87:0]        nacc;
  logic [57:0]        dr;
  logic [39:0]        dq;
  logic               div_skip;
  logic [38:0]        acc_pre;
  logic [33:0]        m;
  logic signed [15:0] res_x, res_y;
  logic [31:0]        in_stamp_q;

  assign status.item_abs = in_absolute;

  // Magnitudes of the incoming deltas; the most negative value maps to 2^15.
  logic [15:0] in_ax, in_ay;
  assign in_ax = in_delta_x[15] ? 16'(-in_delta_x) : in_delta_x;
  assign in_ay = in_delta_y[15] ? 16'(-in_delta_y) : in_delta_y;

  logic [31:0] sq_sum;
  assign sq_sum = sq + 32'(32'(ay) * 32'(ay));

  logic [63:0] root_trial;
  assign root_trial = root_res + root_bit;

  logic [57:0] dvs_sh;
  assign dvs_sh = {dvs, 16'b0};

  logic [58:0] div_r2;
  assign div_r2 = {dr, dq[39]};

  logic [39:0] gain;
  logic [63:0] gain_prod;
  logic [38:0] acc;
  assign acc       = div_skip ? acc_pre : ((dq > 40'(ACC_MAX)) ? ACC_MAX : dq[38:0]);
  assign gain      = 40'(acc) + 40'h1_0000;
  assign gain_prod = 64'(gain) * 64'(sensitivity);

  // Shared axis unit: scale one delta by m, add its carry, floor and saturate.
  logic               ax_sel;
  logic [15:0]        ad;
  logic               neg;
  logic [15:0]        carry;
  logic [49:0]        mag;
  logic signed [35:0] vpos, v;
  logic signed [19:0] ip;
  logic               sat, oor;
  logic signed [15:0] axis_out;
  logic [15:0]        axis_carry;

  always_comb begin
    ax_sel   = (cmd.op == OP_AXY);
    ad       = ax_sel ? ay : ax;
    neg      = ax_sel ? dy[15] : dx[15];
    carry    = ax_sel ? rem_y : rem_x;
    mag      = 50'(ad) * 50'(m);
    sat      = (mag[49:33] != '0);
    vpos     = $signed({2'b0, mag[33:0]});
    v        = $signed({20'b0, carry}) + (neg ? -vpos : vpos);
    ip       = v[35:16];
    oor      = (ip > 20'sd32767) || (ip < -20'sd32768);
    if (sat) begin
      axis_out   = neg ? 16'sh8000 : 16'sh7FFF;
      axis_carry = '0;
    end else if (oor) begin
      axis_out   = ip[19] ? 16'sh8000 : 16'sh7FFF;
      axis_carry = '0;
    end else begin
      axis_out   = ip[15:0];
      axis_carry = v[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_gain  <= '0;
      sensitivity <= 24'h01_0000;
      tick_rate   <= 32'd1000000;
      last_stamp  <= '0;
      rem_x       <= '0;
      rem_y       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ACCEL_GAIN:  accel_gain  <= cfg_data[23:0];
          REG_SENSITIVITY: sensitivity <= cfg_data[23:0];
          REG_TICK_RATE:   tick_rate   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_SQX) begin
        last_stamp <= in_stamp_q;
      end
      if (cmd.op == OP_AXX) begin
        rem_x <= axis_carry;
      end
      if (cmd.op == OP_AXY) begin
        rem_y <= axis_carry;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        dx         <= in_delta_x;
        dy         <= in_delta_y;
        abs_flag   <= in_absolute;
        ax         <= in_ax;
        ay         <= in_ay;
        in_stamp_q <= in_stamp;
      end
      OP_SQX: begin
        sq      <= 32'(ax) * 32'(ax);
        elapsed <= in_stamp_q - last_stamp;
      end
      OP_SQY: begin
        root_n   <= {sq_sum, 32'b0};
        root_res <= '0;
        root_bit <= 64'h4000_0000_0000_0000;
        dvs      <= 42'(elapsed) * 42'(MS_PER_S);
      end
      OP_ROOT: begin
        if (root_n >= root_trial) begin
          root_n   <= root_n - root_trial;
          root_res <= (root_res >> 1) + root_bit;
        end else begin
          root_res <= root_res >> 1;
        end
        root_bit <= root_bit >> 2;
      end
      OP_MULA: begin
        pa <= 56'(accel_gain) * 56'(root_res[31:0]);
      end
      OP_MULL: begin
        nacc <= 88'(60'(pa[27:0]) * 60'(tick_rate));
      end
      OP_MULH: begin
        nacc <= nacc + (88'(60'(pa[55:28]) * 60'(tick_rate)) << 28);
      end
      OP_DSET: begin
        // Zero elapsed time saturates the speed unless gain or root is zero; a
        // quotient of 2^40 or more is caught here, leaving 40 quotient bits to find.
        if (elapsed == '0) begin
          div_skip <= 1'b1;
          acc_pre  <= (accel_gain != '0 && root_res[31:0] != '0) ? ACC_MAX : '0;
        end else begin
          div_skip <= (58'(nacc[87:40]) >= dvs_sh);
          acc_pre  <= ACC_MAX;
        end
        dr <= 58'(nacc[87:40]);
        dq <= nacc[39:0];
      end
      OP_DIV: begin
        if (div_r2 >= {1'b0, dvs_sh}) begin
          dr <= 58'(div_r2 - {1'b0, dvs_sh});
          dq <= {dq[38:0], 1'b1};
        end else begin
          dr <= div_r2[57:0];
          dq <= {dq[38:0], 1'b0};
        end
      end
      OP_GAIN: begin
        m <= (gain_prod[63:16] > 48'(SAT_TH)) ? SAT_TH : gain_prod[49:16];
      end
      OP_AXX: begin
        res_x <= axis_out;
      end
      OP_AXY: begin
        res_y <= axis_out;
      end
      OP_FIN: begin
        out_x <= abs_flag ? dx : res_x;
        out_y <= abs_flag ? dy : res_y;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/pointer_velocity_accel_core.sv
`default_nettype none
// Channel   Dir  Handshake          Word
// in_ch     in   valid/ready        delta_x, delta_y, stamp, absolute
// out_ch    out  valid/ready        out_x, out_y
// cfg       in   cfg_we, no stall   cfg_index, cfg_data
//
// A relative word runs the 32-step square root and 40-step restoring divider
// before its result is valid; an absolute word goes straight to the final step.
// One word is in flight at a time; in_ch.ready is high only while the block is idle.
// The result sits in an output register; a stalled out_ch holds the block in its
// final step until the register frees. Reset (rst, synchronous) restores the
// register defaults and clears the stored stamp and both carries.
module pointer_velocity_accel_core
  import pva_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_BITS-1:0] cfg_data,
  pva_in_if.sink                   in_ch,
  pva_out_if.source                out_ch
);

  pva_cmd_t    cmd;
  pva_status_t status;

  // For a relative word the controller sequences the shared arithmetic: two squarings, the root,
  // the speed product, the division, the gain and then each axis in turn.
  pva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the configuration, the stored stamp and carries, and
  // the output register that parts the result from the working registers.
  pva_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_delta_x  (in_ch.delta_x),
    .in_delta_y  (in_ch.delta_y),
    .in_stamp    (in_ch.stamp),
    .in_absolute (in_ch.absolute),
    .cmd         (cmd),
    .status      (status),
    .out_x       (out_ch.out_x),
    .out_y       (out_ch.out_y)
  );

endmodule
`default_nettype wire
